/* rtl/lj_pkg.sv */
package lj_pkg;

    localparam int LJ_FRAC_BITS = 16;
    localparam int LJ_WORD = 32;
    localparam logic [31:0] LJ_REG_RESET = 32'd65536;

    localparam logic LJ_REG_WELL_DEPTH   = 1'b0;
    localparam logic LJ_REG_LENGTH_SCALE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    // one restoring division step: {quotient bit, new remainder}
    function automatic logic [LJ_WORD:0] div_step(
        input logic [LJ_WORD-1:0] rem,
        input logic               bit_in,
        input logic [LJ_WORD-1:0] dvs
    );
        logic [LJ_WORD:0] t;
        logic [LJ_WORD:0] d;
        t = {rem, bit_in};
        d = t - {1'b0, dvs};
        if (t >= {1'b0, dvs})
        begin
            div_step = {1'b1, d[LJ_WORD-1:0]};
        end
        else
        begin
            div_step = {1'b0, t[LJ_WORD-1:0]};
        end
    endfunction

endpackage

/* rtl/lj_mul64.sv */
module lj_mul64 (
    input  logic         clk,
    input  logic         en,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] p
);

    logic [63:0]  pp_reg [4];
    logic [127:0] p_reg;

    // 32x32 partial products, then one sum stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg[0] <= a[31:0] * b[31:0];
            pp_reg[1] <= a[31:0] * b[63:32];
            pp_reg[2] <= a[63:32] * b[31:0];
            pp_reg[3] <= a[63:32] * b[63:32];
            p_reg     <= {64'd0, pp_reg[0]}
                       + {32'd0, pp_reg[1], 32'd0}
                       + {32'd0, pp_reg[2], 32'd0}
                       + {pp_reg[3], 64'd0};
        end
    end

    assign p = p_reg;

endmodule

/* rtl/lennard_jones_pair_kernel.sv */
// Lennard-Jones 12-6 pair kernel. Each distance r (unsigned Q16.16) transferred in
// gives one result: the pair potential 4*eps*(s6^2 - s6) and the force magnitude
// 24*eps*(2*s6^2 - s6)/r, both signed Q32.32 and saturated, with s6 = (sigma/r)^6.
// Status in tuser: 0 ok, 1 a result saturated, 2 zero distance (results zero).
// Fully pipelined: one distance is accepted every cycle while the result side is not
// stalled. Each passes a 64-step divider for sigma/r, a chain of split 64x64 multipliers
// and a 65-step divider for the force. A stall on the result side holds the whole pipeline.
// eps and sigma may only be written while no item is in flight.
module lennard_jones_pair_kernel #(
    parameter int FRAC_BITS = lj_pkg::LJ_FRAC_BITS
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   s_tdata,   // distance
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // potential, force_res
    output logic [1:0]    m_tuser,   // status
    input  logic          cfg_we,
    input  logic          cfg_addr,
    input  logic [31:0]   cfg_wdata
);

    import lj_pkg::*;

    localparam int DIV1_STEPS = 64;
    localparam int DIV2_STEPS = 65;
    localparam int SIDE = 13;
    localparam int LAT = DIV1_STEPS + SIDE + 1 + DIV2_STEPS + 1;

    typedef struct packed {
        logic        big;
        logic        hsat;
        logic        fneg;
        logic        psat;
        logic [31:0] r;
        logic [63:0] pot;
    } fx_t;

    logic        adv;
    logic [LAT-1:0] vld_reg;
    logic [31:0] well_depth_reg;
    logic [31:0] length_scale_reg;

    assign adv      = !vld_reg[LAT-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            well_depth_reg   <= LJ_REG_RESET;
            length_scale_reg <= LJ_REG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                LJ_REG_WELL_DEPTH:   well_depth_reg   <= cfg_wdata;
                LJ_REG_LENGTH_SCALE: length_scale_reg <= cfg_wdata;
                default:             well_depth_reg   <= well_depth_reg;
            endcase
        end
    end

    // sigma * 2^32 / r
    logic [31:0] d1_rem_reg [DIV1_STEPS];
    logic [63:0] d1_dvd_reg [DIV1_STEPS];
    logic [31:0] d1_r_reg   [DIV1_STEPS];

    for (genvar i = 0; i < DIV1_STEPS; i++)
    begin : g_div1
        logic [31:0] rem_in;
        logic [31:0] r_in;
        logic [63:0] dvd_in;
        logic [32:0] step;
        if (i == 0)
        begin : g_first
            assign rem_in = '0;
            assign dvd_in = {length_scale_reg, 32'd0};
            assign r_in   = s_tdata;
        end
        else
        begin : g_rest
            assign rem_in = d1_rem_reg[i-1];
            assign dvd_in = d1_dvd_reg[i-1];
            assign r_in   = d1_r_reg[i-1];
        end
        assign step = div_step(rem_in, dvd_in[63], r_in);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                d1_rem_reg[i] <= step[31:0];
                d1_dvd_reg[i] <= {dvd_in[62:0], step[32]};
                d1_r_reg[i]   <= r_in;
            end
        end
    end

    logic [63:0]  q;
    logic [127:0] p1;
    logic [127:0] p2;
    logic [127:0] p3;
    logic [127:0] p4;
    logic [63:0]  q_d_reg [2];
    logic [63:0]  s_d_reg [2];
    logic [31:0]  r_pipe_reg [SIDE];
    logic         big_pipe_reg [SIDE];
    logic [SIDE-1:0] hit;

    assign q = d1_dvd_reg[DIV1_STEPS-1];

    lj_mul64 u_mul_q2 (.clk(clk), .en(adv), .a(q), .b(q), .p(p1));
    lj_mul64 u_mul_q3 (.clk(clk), .en(adv), .a(p1[95:32]), .b(q_d_reg[1]), .p(p2));
    lj_mul64 u_mul_s6 (.clk(clk), .en(adv), .a(p2[95:32]), .b(p2[95:32]), .p(p3));
    lj_mul64 u_mul_ss (.clk(clk), .en(adv), .a(p3[95:32]), .b(p3[95:32]), .p(p4));

    // s6 or an earlier power beyond 64 bits
    always_comb
    begin
        hit    = '0;
        hit[1] = |p1[127:96];
        hit[3] = |p2[127:96];
        hit[5] = |p3[127:96];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_d_reg[0]      <= q;
            q_d_reg[1]      <= q_d_reg[0];
            s_d_reg[0]      <= p3[95:32];
            s_d_reg[1]      <= s_d_reg[0];
            r_pipe_reg[0]   <= d1_r_reg[DIV1_STEPS-1];
            big_pipe_reg[0] <= 1'b0;
            for (int j = 1; j < SIDE; j++)
            begin
                r_pipe_reg[j]   <= r_pipe_reg[j-1];
                big_pipe_reg[j] <= big_pipe_reg[j-1] | hit[j-1];
            end
        end
    end

    // |s6^2 - s6| and |2*s6^2 - s6|
    logic [95:0] a_w;
    logic [96:0] b_w;
    logic [95:0] dp_reg;
    logic [96:0] df_reg;
    logic [1:0]  neg_reg [3];

    assign a_w = p4[127:32];
    assign b_w = p4[127:31];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_reg[0][0] <= a_w < {32'd0, s_d_reg[1]};
            neg_reg[0][1] <= b_w < {33'd0, s_d_reg[1]};
            dp_reg <= (a_w < {32'd0, s_d_reg[1]}) ? ({32'd0, s_d_reg[1]} - a_w)
                                                   : (a_w - {32'd0, s_d_reg[1]});
            df_reg <= (b_w < {33'd0, s_d_reg[1]}) ? ({33'd0, s_d_reg[1]} - b_w)
                                                   : (b_w - {33'd0, s_d_reg[1]});
            neg_reg[1] <= neg_reg[0];
            neg_reg[2] <= neg_reg[1];
        end
    end

    logic [127:0] pl;
    logic [127:0] ph;
    logic [127:0] fl;
    logic [127:0] fh;

    lj_mul64 u_mul_pl (.clk(clk), .en(adv), .a(dp_reg[63:0]),
                       .b({32'd0, well_depth_reg}), .p(pl));
    lj_mul64 u_mul_ph (.clk(clk), .en(adv), .a({32'd0, dp_reg[95:64]}),
                       .b({32'd0, well_depth_reg}), .p(ph));
    lj_mul64 u_mul_fl (.clk(clk), .en(adv), .a(df_reg[63:0]),
                       .b({32'd0, well_depth_reg}), .p(fl));
    lj_mul64 u_mul_fh (.clk(clk), .en(adv), .a({31'd0, df_reg[96:64]}),
                       .b({32'd0, well_depth_reg}), .p(fh));

    logic [127:0] pm_reg;
    logic [129:0] fm_reg;
    logic [1:0]   neg_y_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pm_reg    <= pl + {ph[63:0], 64'd0};
            fm_reg    <= {2'd0, fl} + {fh[65:0], 64'd0};
            neg_y_reg <= neg_reg[2];
        end
    end

    // potential saturation, force dividend 24 * eps * d
    logic [127:0] pmag;
    logic         psat_w;
    logic [63:0]  pot_w;
    logic [63:0]  pot_reg;
    logic         psat_reg;
    logic         fneg_z_reg;
    logic [134:0] fd_reg;

    assign pmag = pm_reg >> (FRAC_BITS - 2);

    always_comb
    begin
        if (neg_y_reg[0])
        begin
            psat_w = (|pmag[127:64]) || (pmag[63] && (|pmag[62:0]));
            pot_w  = psat_w ? 64'h8000_0000_0000_0000 : (64'd0 - pmag[63:0]);
        end
        else
        begin
            psat_w = |pmag[127:63];
            pot_w  = psat_w ? 64'h7FFF_FFFF_FFFF_FFFF : pmag[63:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pot_reg    <= pot_w;
            psat_reg   <= psat_w;
            fneg_z_reg <= neg_y_reg[1];
            fd_reg     <= ({5'd0, fm_reg} << 4) + ({5'd0, fm_reg} << 3);
        end
    end

    // force division by r, quotient bits 64 down to 0
    fx_t          fx_reg  [DIV2_STEPS + 1];
    logic [31:0]  d2_rem_reg [DIV2_STEPS + 1];
    logic [64:0]  d2_dvd_reg [DIV2_STEPS + 1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fx_reg[0].big  <= big_pipe_reg[SIDE-1];
            fx_reg[0].hsat <= fd_reg[134:65] >= {38'd0, r_pipe_reg[SIDE-1]};
            fx_reg[0].fneg <= fneg_z_reg;
            fx_reg[0].psat <= psat_reg;
            fx_reg[0].r    <= r_pipe_reg[SIDE-1];
            fx_reg[0].pot  <= pot_reg;
            d2_rem_reg[0]  <= fd_reg[96:65];
            d2_dvd_reg[0]  <= fd_reg[64:0];
        end
    end

    for (genvar i = 1; i <= DIV2_STEPS; i++)
    begin : g_div2
        logic [32:0] step;
        assign step = div_step(d2_rem_reg[i-1], d2_dvd_reg[i-1][64], fx_reg[i-1].r);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                fx_reg[i]     <= fx_reg[i-1];
                d2_rem_reg[i] <= step[31:0];
                d2_dvd_reg[i] <= {d2_dvd_reg[i-1][63:0], step[32]};
            end
        end
    end

    // result selection
    fx_t         fx_last;
    logic [64:0] fq;
    logic        fsat_w;
    logic [63:0] force_w;
    logic [63:0] pot_out_next;
    logic [63:0] force_out_next;
    status_t     status_next;
    logic [63:0] pot_out_reg;
    logic [63:0] force_out_reg;
    status_t     status_reg;

    assign fx_last = fx_reg[DIV2_STEPS];
    assign fq      = d2_dvd_reg[DIV2_STEPS];

    always_comb
    begin
        if (fx_last.fneg)
        begin
            fsat_w  = fx_last.hsat || fq[64] || (fq[63] && (|fq[62:0]));
            force_w = fsat_w ? 64'h8000_0000_0000_0000 : (64'd0 - fq[63:0]);
        end
        else
        begin
            fsat_w  = fx_last.hsat || fq[64] || fq[63];
            force_w = fsat_w ? 64'h7FFF_FFFF_FFFF_FFFF : fq[63:0];
        end

        if (fx_last.r == '0)
        begin
            pot_out_next   = '0;
            force_out_next = '0;
            status_next    = ST_ZERO;
        end
        else if (fx_last.big)
        begin
            if (well_depth_reg != '0)
            begin
                pot_out_next   = 64'h7FFF_FFFF_FFFF_FFFF;
                force_out_next = 64'h7FFF_FFFF_FFFF_FFFF;
                status_next    = ST_SAT;
            end
            else
            begin
                pot_out_next   = '0;
                force_out_next = '0;
                status_next    = ST_OK;
            end
        end
        else
        begin
            pot_out_next   = fx_last.pot;
            force_out_next = force_w;
            status_next    = (fx_last.psat || fsat_w) ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pot_out_reg   <= pot_out_next;
            force_out_reg <= force_out_next;
            status_reg    <= status_next;
        end
    end

    assign m_tdata = {force_out_reg, pot_out_reg};
    assign m_tuser = status_reg;

endmodule

/* tb/testbench.sv */
module testbench;
    import lj_pkg::*;

    typedef struct {
        logic signed [63:0] pot;
        logic signed [63:0] frc;
        status_t            st;
    } lj_result_t;

    class lj_scoreboard;
        bit [31:0]  eps;
        bit [31:0]  sigma;
        lj_result_t pending[$];
        int         errors;

        function new();
            eps = LJ_REG_RESET;
            sigma = LJ_REG_RESET;
            errors = 0;
        endfunction

        function bit [63:0] clamp(input bit [191:0] m, input bit neg, inout bit sat);
            if (!neg)
            begin
                if (m[191:63] != 0)
                begin
                    sat = 1;
                    return 64'h7FFF_FFFF_FFFF_FFFF;
                end
                return m[63:0];
            end
            if (m[191:64] != 0 || m[63:0] > 64'h8000_0000_0000_0000)
            begin
                sat = 1;
                return 64'h8000_0000_0000_0000;
            end
            return 64'd0 - m[63:0];
        endfunction

        // predict the result for one accepted distance
        function void note_distance(bit [31:0] r);
            bit [191:0] q, q2, q3, s6, sq, a, d, m;
            bit         big, neg, sat;
            lj_result_t e;
            e.pot = 0;
            e.frc = 0;
            e.st = ST_OK;
            sat = 0;
            if (r == 0)
            begin
                e.st = ST_ZERO;
                pending.push_back(e);
                return;
            end
            q = {128'd0, sigma, 32'd0} / r;
            q2 = (q * q) >> 32;
            big = (q2[191:64] != 0);
            q3 = (q2 * q) >> 32;
            big = big || (q3[191:64] != 0);
            s6 = (q3 * q3) >> 32;
            big = big || (s6[191:64] != 0);
            if (big)
            begin
                if (eps != 0)
                begin
                    e.pot = 64'h7FFF_FFFF_FFFF_FFFF;
                    e.frc = 64'h7FFF_FFFF_FFFF_FFFF;
                    e.st = ST_SAT;
                end
                pending.push_back(e);
                return;
            end
            sq = s6 * s6;
            a = sq >> 32;
            neg = a < s6;
            d = neg ? s6 - a : a - s6;
            m = (d * eps * 4) >> LJ_FRAC_BITS;
            e.pot = clamp(m, neg, sat);
            a = sq >> 31;
            neg = a < s6;
            d = neg ? s6 - a : a - s6;
            m = (d * eps * 24) / r;
            e.frc = clamp(m, neg, sat);
            e.st = sat ? ST_SAT : ST_OK;
            pending.push_back(e);
        endfunction

        function void check_result(logic [127:0] data, logic [1:0] user);
            lj_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result pot=%h force=%h status=%0d",
                         $time, data[63:0], data[127:64], user);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[63:0] !== e.pot)
            begin
                $display("%0t: potential expected %h actual %h", $time, e.pot, data[63:0]);
                errors++;
            end
            if (data[127:64] !== e.frc)
            begin
                $display("%0t: force expected %h actual %h", $time, e.frc, data[127:64]);
                errors++;
            end
            if (user !== e.st)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.st, user);
                errors++;
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [31:0]   s_tdata;     // distance
    logic          m_tvalid;
    logic          m_tready;
    logic [127:0]  m_tdata;     // potential, force_res
    logic [1:0]    m_tuser;     // status
    logic          cfg_we;
    logic          cfg_addr;
    logic [31:0]   cfg_wdata;

    lj_scoreboard  sb;
    bit            calm;
    int            sent;
    int            quiet_cycles;

    lennard_jones_pair_kernel uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    task automatic send_distance(bit [31:0] r);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= r;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_distance(r);
        sent++;
    endtask

    task automatic write_reg(logic addr, bit [31:0] value);
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (160) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == LJ_REG_WELL_DEPTH)
            sb.eps = value;
        else
            sb.sigma = value;
    endtask

    function automatic bit [31:0] pick_distance();
        bit [63:0] span;
        if ($urandom_range(0, 2) == 0 || sb.sigma == 0)
            return $urandom();
        // near the well, where the potential changes sign
        span = {32'd0, sb.sigma} * 3;
        span = (sb.sigma >> 1) + ({32'd0, $urandom()} % (span + 1));
        return (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
    endfunction

    // receiver with random stalls and one long hold-off
    initial
    begin
        bit held;
        held = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && sent >= 40)
            begin
                held = 1;
                m_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 3000)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        bit [31:0] eps_set[5];
        bit [31:0] sig_set[5];
        sb = new();
        calm = 0;
        sent = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = LJ_REG_WELL_DEPTH;
        cfg_wdata = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset registers, then full-scale and zero eps and sigma
        send_distance(32'd0);
        send_distance(32'd1);
        send_distance(32'hFFFF_FFFF);
        send_distance(32'h0001_0000);
        send_distance(32'h0001_1F5A);
        send_distance(32'h0000_8000);
        send_distance(32'h0000_4000);
        send_distance(32'h0000_2000);
        send_distance(32'h0002_0000);
        send_distance(32'h5555_5555);
        send_distance(32'hAAAA_AAAA);
        write_reg(LJ_REG_WELL_DEPTH, 32'hFFFF_FFFF);
        write_reg(LJ_REG_LENGTH_SCALE, 32'hFFFF_FFFF);
        send_distance(32'hFFFF_FFFF);
        send_distance(32'h8000_0000);
        send_distance(32'h0001_0000);
        send_distance(32'd0);
        write_reg(LJ_REG_WELL_DEPTH, 32'd0);
        send_distance(32'd1);
        send_distance(32'h0001_0000);
        write_reg(LJ_REG_WELL_DEPTH, 32'h0001_0000);
        write_reg(LJ_REG_LENGTH_SCALE, 32'd0);
        send_distance(32'd1);
        send_distance(32'h0001_0000);

        eps_set = '{32'h0001_0000, 32'hFFFF_FFFF, 32'd0, 32'h0000_0100, 32'h0003_8000};
        sig_set = '{32'h0001_0000, 32'h0000_0001, 32'h0000_C000, 32'hFFFF_FFFF, 32'h0003_0000};
        for (int p = 0; p < 5; p++)
        begin
            write_reg(LJ_REG_WELL_DEPTH, p == 0 ? $urandom() : eps_set[p]);
            write_reg(LJ_REG_LENGTH_SCALE, p == 0 ? $urandom_range(1, 32'h0010_0000) :
                      sig_set[p]);
            calm = (p == 4);
            for (int i = 0; i < 80; i++)
                send_distance(pick_distance());
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
